// File: rtl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types and constants of the date string validator.
// ----------------------------------------------------------------------------
package dsv_pkg;

  localparam int VAL_W = 17;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [VAL_W-1:0] YEAR_SAT = 17'd99999;
  localparam logic [VAL_W-1:0] YEAR_MIN = 17'd1900;
  localparam logic [13:0]      YEAR_RST = 14'd2019;

  // q = (y * RECIP_100) >> RECIP_SHIFT equals y / 100 for y below 16384
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [2:0] SEP_POS_1 = 3'd1;
  localparam logic [2:0] SEP_POS_2 = 3'd2;
  localparam logic [2:0] SEP_POS_3 = 3'd3;
  localparam logic [2:0] SEP_POS_4 = 3'd4;
  localparam logic [2:0] SEP_POS_5 = 3'd5;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_LAYOUT = 3'd1,
    ERR_YEAR   = 3'd2,
    ERR_FEB    = 3'd3,
    ERR_DAY    = 3'd4,
    ERR_MONTH  = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PARSE,
    ST_LEAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] s1;
    logic [2:0] s2;
  } layout_t;

endpackage

// File: rtl/dsv_digit_unit.sv
// ----------------------------------------------------------------------------
// dsv_digit_unit
// Shared decimal accumulate step: acc * 10 + digit, saturating.
// ----------------------------------------------------------------------------
module dsv_digit_unit import dsv_pkg::*; (
  input  logic [VAL_W-1:0] acc,
  input  logic [7:0]       ch,
  output logic             is_digit,
  output logic [VAL_W-1:0] sum
);

  logic [VAL_W+3:0] wide;
  logic [7:0]       digit;

  always_comb begin
    is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    digit    = ch - CHAR_ZERO;
    wide     = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(VAL_W-4){1'b0}}, digit};
    if (wide > {4'b0000, YEAR_SAT}) begin
      sum = YEAR_SAT;
    end else begin
      sum = wide[VAL_W-1:0];
    end
  end

endmodule

// File: rtl/dsv_char_buf.sv
// ----------------------------------------------------------------------------
// dsv_char_buf
// Character store with fill count, overflow flag and separator decode.
// ----------------------------------------------------------------------------
module dsv_char_buf import dsv_pkg::*; #(
  parameter int MAX_CHARS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [7:0]                   wr_char,
  input  logic                         clear,
  input  logic [$clog2(MAX_CHARS)-1:0] rd_pos,
  output logic [7:0]                   rd_char,
  output logic                         too_long,
  output layout_t                      lay
);

  localparam int IW = $clog2(MAX_CHARS);
  localparam int CW = $clog2(MAX_CHARS + 1);

  logic [7:0]    store [MAX_CHARS];
  logic [CW-1:0] count;
  logic          nul_seen;
  logic [5:1]    sep;

  // once a nul arrives everything after it reads as nul
  always_ff @(posedge clk) begin
    if (wr_en && !clear && (count < CW'(MAX_CHARS))) begin
      store[count[IW-1:0]] <= nul_seen ? CHAR_NUL : wr_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count    <= '0;
      too_long <= 1'b0;
      nul_seen <= 1'b0;
    end else if (wr_en) begin
      if (count < CW'(MAX_CHARS)) begin
        count <= count + CW'(1);
      end else begin
        too_long <= 1'b1;
      end
      if (wr_char == CHAR_NUL) begin
        nul_seen <= 1'b1;
      end
    end
  end

  always_comb begin
    rd_char = (CW'(rd_pos) < count) ? store[rd_pos] : CHAR_NUL;
    for (int i = 1; i <= 5; i++) begin
      sep[i] = (CW'(i) < count) &&
               ((store[i] == CHAR_DASH) || (store[i] == CHAR_SLASH));
    end
    lay.ok = !too_long;
    lay.s1 = SEP_POS_1;
    lay.s2 = SEP_POS_3;
    if (sep[1] && sep[3]) begin
      lay.s1 = SEP_POS_1;
      lay.s2 = SEP_POS_3;
    end else if (sep[1] && sep[4]) begin
      lay.s1 = SEP_POS_1;
      lay.s2 = SEP_POS_4;
    end else if (sep[2] && sep[4]) begin
      lay.s1 = SEP_POS_2;
      lay.s2 = SEP_POS_4;
    end else if (sep[2] && sep[5]) begin
      lay.s1 = SEP_POS_2;
      lay.s2 = SEP_POS_5;
    end else begin
      lay.ok = 1'b0;
    end
  end

endmodule

// File: rtl/date_string_validator.sv
// ----------------------------------------------------------------------------
// date_string_validator
// Checks a day-month-year date string delivered one character per request.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one character per request, last_char
// marks the final one. Characters of a string are taken one per cycle.
// After the final character the block drops in_ready and a small sequencer
// walks the stored characters through one shared multiply-by-ten digit unit,
// one position per cycle, then applies the divide-by-100 reciprocal for
// the leap rule and then makes the final checks.
// The result goes out on out_valid/out_ready; a layout error skips the
// digit walk and the leap step. current_year is written over the APB port
// at address 0. Write it only while idle; the block itself does not check.
// The result sits in an output register: while the receiver stalls, the
// block still takes the characters of the next string, and only its own
// final check waits until the held result is taken.
// Reset (synchronous, active high) empties the character store, drops any
// pending result and sets current_year to 2019.
// ----------------------------------------------------------------------------
module date_string_validator import dsv_pkg::*; #(
  parameter int MAX_CHARS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        date_ok,
  output logic [2:0]  error_code,
  output logic [6:0]  day_value,
  output logic [6:0]  month_value,
  output logic [16:0] year_value
);

  localparam int IW = $clog2(MAX_CHARS);

  state_t           state, state_next;
  logic [13:0]      current_year;
  logic [IW-1:0]    pos;
  logic [VAL_W-1:0] acc, day, mon, year;
  logic             stop;
  logic [7:0]       quot;
  logic             in_acc, clear, load_out;
  logic [7:0]       rd_char;
  logic             too_long;
  layout_t          lay;
  logic             is_digit;
  logic [VAL_W-1:0] dsum;
  logic [26:0]      recip_prod;
  logic [13:0]      year14, quot100;
  logic             leap;
  err_t             err;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {18'd0, current_year} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_year <= YEAR_RST;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      current_year <= pwdata[13:0];
    end
  end

  dsv_char_buf #(
    .MAX_CHARS(MAX_CHARS)
  ) u_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_acc),
    .wr_char  (char_code),
    .clear    (clear),
    .rd_pos   (pos),
    .rd_char  (rd_char),
    .too_long (too_long),
    .lay      (lay)
  );

  dsv_digit_unit u_digit (
    .acc      (acc),
    .ch       (rd_char),
    .is_digit (is_digit),
    .sum      (dsum)
  );

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    clear      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && last_char) begin
          state_next = ST_PARSE;
        end
      end
      ST_PARSE: begin
        if (!lay.ok) begin
          state_next = ST_DONE;
        end else if (pos == IW'(MAX_CHARS - 1)) begin
          state_next = ST_LEAP;
        end
      end
      ST_LEAP: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          clear      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // digit walk over the stored string
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      pos  <= '0;
      acc  <= '0;
      stop <= 1'b0;
    end else if (state == ST_PARSE && lay.ok) begin
      pos <= pos + IW'(1);
      if (pos == IW'(lay.s1)) begin
        day  <= acc;
        acc  <= '0;
        stop <= 1'b0;
      end else if (pos == IW'(lay.s2)) begin
        mon  <= acc;
        acc  <= '0;
        stop <= 1'b0;
      end else if (!stop && is_digit) begin
        acc <= dsum;
        if (pos == IW'(MAX_CHARS - 1)) begin
          year <= dsum;
        end
      end else begin
        stop <= 1'b1;
        if (pos == IW'(MAX_CHARS - 1)) begin
          year <= acc;
        end
      end
    end
  end

  // leap rule: quotient by 100 through a reciprocal
  assign year14     = year[13:0];
  assign recip_prod = year14 * RECIP_100;

  always_ff @(posedge clk) begin
    if (state == ST_LEAP) begin
      quot <= recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    end
  end

  always_comb begin
    quot100 = {quot, 6'd0} + {1'b0, quot, 5'd0} + {4'd0, quot, 2'b00};
    leap    = (year14[1:0] == 2'b00) && ((year14 != quot100) || (quot[1:0] == 2'b00));
    err     = ERR_OK;
    if (!lay.ok) begin
      err = ERR_LAYOUT;
    end else if ((year < YEAR_MIN) || (year > {3'd0, current_year})) begin
      err = ERR_YEAR;
    end else if (mon == 17'd2) begin
      if (!(((day >= 17'd1) && (day <= 17'd28)) || ((day == 17'd29) && leap))) begin
        err = ERR_FEB;
      end
    end else if ((mon == 17'd4) || (mon == 17'd6) || (mon == 17'd9) || (mon == 17'd11)) begin
      if ((day < 17'd1) || (day > 17'd30)) begin
        err = ERR_DAY;
      end
    end else if ((mon >= 17'd1) && (mon <= 17'd12)) begin
      if ((day < 17'd1) || (day > 17'd31)) begin
        err = ERR_DAY;
      end
    end else begin
      err = ERR_MONTH;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      date_ok     <= (err == ERR_OK);
      error_code  <= err;
      day_value   <= lay.ok ? day[6:0] : 7'd0;
      month_value <= lay.ok ? mon[6:0] : 7'd0;
      year_value  <= lay.ok ? year : 17'd0;
    end
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// date string validator testbench
// Feeds date strings one character per request, with random gaps on the
// character side and random stalls on the result side, and checks every result
// against the directed table or an in-bench model of the parser and date
// rules. A directed table covers the layouts, the range edges and the
// malformed strings; random strings then run under several APB year limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dsv_pkg::*;

  localparam int MAX_CHARS = 10;
  localparam int SETTLE = MAX_CHARS + 10;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_CHARS = 160;
  localparam logic [2:0] REG_CURRENT_YEAR = 3'd0;

  typedef struct packed {
    logic        ok;
    logic [2:0]  err;
    logic [6:0]  day;
    logic [6:0]  mon;
    logic [16:0] yr;
  } date_result_t;

  typedef struct packed {
    logic [127:0] text;
    logic [4:0]   len;
    logic         typed;
    logic [2:0]   err;
    logic [6:0]   day;
    logic [6:0]   mon;
    logic [16:0]  yr;
  } date_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        last_char;
  logic        out_valid;
  logic        out_ready;
  logic        date_ok;
  logic [2:0]  error_code;
  logic [6:0]  day_value;
  logic [6:0]  month_value;
  logic [16:0] year_value;

  logic [7:0]   chars_held [16];
  int unsigned  held_cnt;
  bit           overflowed;
  logic [13:0]  year_limit;

  date_result_t pending_dates [$];
  date_row_t    date_rows [$];
  logic [7:0]   text_q [$];
  bit           typed_now;
  date_result_t typed_result;
  bit           calm;
  bit           failed;
  int unsigned  idle_cycles;

  date_string_validator #(.MAX_CHARS(MAX_CHARS)) u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .date_ok    (date_ok),
    .error_code (error_code),
    .day_value  (day_value),
    .month_value(month_value),
    .year_value (year_value)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] held_at(input int unsigned pos, input int unsigned len);
    if (pos >= len || pos >= 16) return CHAR_NUL;
    return chars_held[pos];
  endfunction

  function automatic bit is_divider(input logic [7:0] c);
    return c == CHAR_DASH || c == CHAR_SLASH;
  endfunction

  function automatic int unsigned read_number(input int unsigned from, input int unsigned upto,
                                              input int unsigned len);
    int unsigned v;
    int unsigned p;
    logic [7:0]  c;
    v = 0;
    for (p = from; p < upto; p++) begin
      c = held_at(p, len);
      if (c < CHAR_ZERO || c > CHAR_NINE) break;
      v = v * 10 + (c - CHAR_ZERO);
      if (v > YEAR_SAT) v = YEAR_SAT;
    end
    return v;
  endfunction

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic date_result_t validate_date();
    date_result_t r;
    int unsigned  len, s1, s2, d, m, y;
    logic [2:0]   e;
    len = 0;
    while (len < held_cnt && len < 16 && chars_held[len] != CHAR_NUL) len++;
    s1 = 0;
    s2 = 0;
    d = 0;
    m = 0;
    y = 0;
    e = ERR_OK;
    if (overflowed) e = ERR_LAYOUT;
    else if (is_divider(held_at(1, len)) && is_divider(held_at(3, len))) begin
      s1 = 1;
      s2 = 3;
    end else if (is_divider(held_at(1, len)) && is_divider(held_at(4, len))) begin
      s1 = 1;
      s2 = 4;
    end else if (is_divider(held_at(2, len)) && is_divider(held_at(4, len))) begin
      s1 = 2;
      s2 = 4;
    end else if (is_divider(held_at(2, len)) && is_divider(held_at(5, len))) begin
      s1 = 2;
      s2 = 5;
    end else e = ERR_LAYOUT;
    if (e != ERR_LAYOUT) begin
      d = read_number(0, s1, len);
      m = read_number(s1 + 1, s2, len);
      y = read_number(s2 + 1, 16, len);
      if (y < YEAR_MIN || y > year_limit) e = ERR_YEAR;
      else begin
        case (m)
          2: if (!((d >= 1 && d <= 28) || (d == 29 && is_leap_year(y)))) e = ERR_FEB;
          4, 6, 9, 11: if (d < 1 || d > 30) e = ERR_DAY;
          1, 3, 5, 7, 8, 10, 12: if (d < 1 || d > 31) e = ERR_DAY;
          default: e = ERR_MONTH;
        endcase
      end
    end
    r.ok = (e == ERR_OK);
    r.err = e;
    r.day = d[6:0];
    r.mon = m[6:0];
    r.yr = y[16:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // request monitor and date model
  always @(posedge clk) begin : monitor
    date_result_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_dates.size() == 0) begin
          $display("%0t ns: result expected none actual error_code %0d day %0d month %0d year %0d",
                   $time, error_code, day_value, month_value, year_value);
          failed = 1'b1;
        end else begin
          want = pending_dates.pop_front();
          check_field("date_ok", want.ok, date_ok);
          check_field("error_code", want.err, error_code);
          check_field("day_value", want.day, day_value);
          check_field("month_value", want.mon, month_value);
          check_field("year_value", want.yr, year_value);
        end
      end
      if (in_valid && in_ready) begin
        if (held_cnt < MAX_CHARS) begin
          chars_held[held_cnt] = char_code;
          held_cnt++;
        end else begin
          overflowed = 1'b1;
        end
        if (last_char) begin
          want = validate_date();
          pending_dates.push_back(typed_now ? typed_result : want);
          held_cnt = 0;
          overflowed = 1'b0;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  initial begin : result_stall
    int unsigned hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        hold = idle_len();
      end
    end
  end

  task automatic send_text();
    int unsigned i, gap;
    for (i = 0; i < text_q.size(); i++) begin
      gap = idle_len();
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      char_code = text_q[i];
      last_char = (i == text_q.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
  endtask

  task automatic settle_idle();
    in_valid = 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_year(input int unsigned v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_CURRENT_YEAR;
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    year_limit = v[13:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic add_row(input logic [127:0] text, input int unsigned len, input bit typed,
                         input err_t err, input int unsigned d, input int unsigned m,
                         input int unsigned y);
    date_row_t row;
    row.text = text;
    row.len = len[4:0];
    row.typed = typed;
    row.err = err;
    row.day = d[6:0];
    row.mon = m[6:0];
    row.yr = y[16:0];
    date_rows.push_back(row);
  endtask

  task automatic push_digits(input int unsigned value, input int unsigned n);
    int unsigned k, p;
    logic [7:0]  digit;
    for (k = n; k > 0; k--) begin
      p = 1;
      repeat (k - 1) p = p * 10;
      digit = 8'((value / p) % 10);
      text_q.push_back(CHAR_ZERO + digit);
    end
  endtask

  function automatic logic [7:0] random_divider();
    return $urandom_range(0, 1) ? CHAR_DASH : CHAR_SLASH;
  endfunction

  task automatic make_date_text();
    int unsigned s1, s2, ylen, d, m, y;
    text_q.delete();
    case ($urandom_range(0, 3))
      0: begin
        s1 = 1;
        s2 = 3;
      end
      1: begin
        s1 = 1;
        s2 = 4;
      end
      2: begin
        s1 = 2;
        s2 = 4;
      end
      default: begin
        s1 = 2;
        s2 = 5;
      end
    endcase
    d = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 31) : $urandom_range(0, 99);
    m = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) begin
      m = 2;
      d = $urandom_range(27, 30);
    end
    case ($urandom_range(0, 5))
      0: y = $urandom_range(19, 24) * 100 + ($urandom_range(0, 1) ? 0 : 4 * $urandom_range(0, 24));
      1: y = $urandom_range(0, 99999);
      default: y = $urandom_range(1880, year_limit + 20);
    endcase
    ylen = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 9 - s2);
    if ($urandom_range(0, 19) == 0) ylen += $urandom_range(1, 3);
    push_digits(d, s1);
    text_q.push_back(random_divider());
    push_digits(m, s2 - s1 - 1);
    text_q.push_back(random_divider());
    push_digits(y, ylen);
    if ($urandom_range(0, 9) == 0)
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  task automatic make_noise_text();
    int unsigned n, k;
    text_q.delete();
    n = $urandom_range(1, 14);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 2))
        0: text_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        1: text_q.push_back(random_divider());
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned spent;
    spent = 0;
    while (spent < budget) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) make_noise_text();
      else make_date_text();
      spent += text_q.size();
      send_text();
    end
  endtask

  initial begin : stimulus
    int unsigned i, k, base, ph, v;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = REG_CURRENT_YEAR;
    pwdata = '0;
    in_valid = 1'b0;
    char_code = '0;
    last_char = 1'b0;
    held_cnt = 0;
    overflowed = 1'b0;
    year_limit = YEAR_RST;
    typed_now = 1'b0;
    typed_result = '0;
    calm = 1'b0;
    failed = 1'b0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed strings, year limit at its reset value
    add_row("29/02/2000", 10, 1, ERR_OK, 29, 2, 2000);
    add_row("29/02/1900", 10, 1, ERR_FEB, 29, 2, 1900);
    add_row("29/02/2016", 10, 1, ERR_OK, 29, 2, 2016);
    add_row("30/02/2000", 10, 1, ERR_FEB, 30, 2, 2000);
    add_row("31/12/2019", 10, 1, ERR_OK, 31, 12, 2019);
    add_row("31/04/2010", 10, 1, ERR_DAY, 31, 4, 2010);
    add_row("00/01/2000", 10, 1, ERR_DAY, 0, 1, 2000);
    add_row("15/13/2000", 10, 1, ERR_MONTH, 15, 13, 2000);
    add_row("15/00/2000", 10, 1, ERR_MONTH, 15, 0, 2000);
    add_row("01/01/1899", 10, 1, ERR_YEAR, 1, 1, 1899);
    add_row("31/02/2020", 10, 1, ERR_YEAR, 31, 2, 2020);
    add_row("1-1-1900", 8, 1, ERR_OK, 1, 1, 1900);
    add_row("1/12/2000", 9, 1, ERR_OK, 1, 12, 2000);
    add_row("12-1-2000", 9, 1, ERR_OK, 12, 1, 2000);
    add_row("12.01.2000", 10, 1, ERR_LAYOUT, 0, 0, 0);
    add_row("01/01/20000", 11, 1, ERR_LAYOUT, 0, 0, 0);
    add_row({"0123456789abcde", 8'hff}, 16, 1, ERR_LAYOUT, 0, 0, 0);
    add_row("1/1/999999", 10, 1, ERR_YEAR, 1, 1, 99999);
    add_row("a/b/2000", 8, 1, ERR_MONTH, 0, 0, 2000);
    add_row({"01/01/", 8'h00, "200"}, 10, 1, ERR_YEAR, 1, 1, 0);
    add_row({8'h00}, 1, 1, ERR_LAYOUT, 0, 0, 0);
    add_row("9/9/12345", 9, 1, ERR_YEAR, 9, 9, 12345);
    add_row("99/11/2000", 10, 1, ERR_DAY, 99, 11, 2000);
    add_row("3-04-2001", 9, 0, ERR_OK, 0, 0, 0);
    add_row({8'h80, "/", 8'h7f, "-1999"}, 8, 0, ERR_OK, 0, 0, 0);

    for (i = 0; i < date_rows.size(); i++) begin
      text_q.delete();
      for (k = 0; k < date_rows[i].len; k++) begin
        base = 8 * (date_rows[i].len - 1 - k);
        text_q.push_back(date_rows[i].text[base +: 8]);
      end
      typed_now = date_rows[i].typed;
      typed_result.ok = (date_rows[i].err == ERR_OK);
      typed_result.err = date_rows[i].err;
      typed_result.day = date_rows[i].day;
      typed_result.mon = date_rows[i].mon;
      typed_result.yr = date_rows[i].yr;
      calm = ($urandom_range(0, 2) == 0);
      send_text();
    end
    typed_now = 1'b0;
    settle_idle();

    // random strings under several year limits
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: v = 1900;
        1: v = 9999;
        2: v = 1899;
        3: v = 2100;
        default: v = $urandom_range(1900, 9999);
      endcase
      write_year(v);
      run_random(RANDOM_CHARS);
      settle_idle();
    end

    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
